// ===== rtl/wsog_pkg.sv =====
package wsog_pkg;

    // Ring depth and the arithmetic widths that follow from it
    localparam int WINDOW   = 15;
    localparam int SLOT_W   = 4;
    localparam int SAMPLE_W = 16;
    localparam int AXES     = 3;
    localparam int AXIS_W   = 2;
    localparam logic [AXIS_W-1:0] AXIS_LAST = 2'd2;

    localparam int SUM_W  = 21;   // signed sum of WINDOW samples
    localparam int SQ_W   = 34;   // unsigned sum of WINDOW squares
    localparam int SQR_W  = 31;   // one squared sample
    localparam int DIFF_W = 21;   // N*v - S
    localparam int NQ_W   = 38;   // N*Q, S^2 and the clamped variance term
    localparam int DD_W   = 40;   // (N*v - S)^2
    localparam int MULT_W = 4;
    localparam int MM_W   = 8;
    localparam int MV_W   = 46;   // m^2 * variance term
    localparam logic [MULT_W-1:0] GATE_MULT_RESET = 4'd2;

    // Sequencer steps
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_A      = 3'd1;
    localparam logic [STEP_W-1:0] STEP_B      = 3'd2;
    localparam logic [STEP_W-1:0] STEP_C      = 3'd3;
    localparam logic [STEP_W-1:0] STEP_D      = 3'd4;
    localparam logic [STEP_W-1:0] STEP_COMMIT = 3'd5;

    // Hold conditions
    localparam logic [1:0] HOLD_NONE = 2'd0;
    localparam logic [1:0] HOLD_IN   = 2'd1;
    localparam logic [1:0] HOLD_OUT  = 2'd2;

    typedef struct packed {
        logic [1:0]        hold;
        logic              br_loop;
        logic [STEP_W-1:0] next;
        logic [STEP_W-1:0] target;
        logic              cap;
        logic              calc_a;
        logic              calc_b;
        logic              calc_c;
        logic              calc_d;
        logic              commit;
    } ctl_t;

    // Control store: one word per step
    function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
        ctl_t w;
        w = '0;
        unique case (step)
            STEP_IDLE:
            begin
                w.hold = HOLD_IN;
                w.next = STEP_A;
                w.cap  = 1'b1;
            end
            STEP_A:
            begin
                w.next   = STEP_B;
                w.calc_a = 1'b1;
            end
            STEP_B:
            begin
                w.next   = STEP_C;
                w.calc_b = 1'b1;
            end
            STEP_C:
            begin
                w.next   = STEP_D;
                w.calc_c = 1'b1;
            end
            STEP_D:
            begin
                w.br_loop = 1'b1;
                w.target  = STEP_A;
                w.next    = STEP_COMMIT;
                w.calc_d  = 1'b1;
            end
            STEP_COMMIT:
            begin
                w.hold   = HOLD_OUT;
                w.next   = STEP_IDLE;
                w.commit = 1'b1;
            end
            default:
            begin
                w.next = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/window_sigma_outlier_gate.sv =====
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: pos_x, pos_y, pos_z
// m_*       out  m_tvalid/m_tready  m_tdata: out_x, out_y, out_z; m_tuser: accepted
// cfg_*     in   cfg_we             cfg_wdata: gate_mult
//
// One sample runs from its transfer to its result through one capture step, a
// four-step loop per axis over the shared difference/variance/gate multipliers,
// and one commit step. The next sample is taken only after the last is committed.
// Reset clears the ring, sums and write slot at once; there is no clearing pass.
// A stalled result holds the commit step; no new sample is taken while it waits.
module window_sigma_outlier_gate
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pos_x [15:0], pos_y [31:16], pos_z [47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_x [15:0], out_y [31:16], out_z [47:32]
    output logic        m_tuser    // accepted [0]
);

    logic [wsog_pkg::STEP_W-1:0] step_reg, step_next;
    wsog_pkg::ctl_t              ctl;
    logic                        hold_now;
    logic                        go;

    logic [wsog_pkg::MULT_W-1:0] gate_mult_reg;
    logic [wsog_pkg::AXIS_W-1:0] axis_reg;
    logic [wsog_pkg::SLOT_W-1:0] slot_reg;
    logic                        ok_reg;

    logic signed [wsog_pkg::SAMPLE_W-1:0] samp_reg [wsog_pkg::AXES];
    logic signed [wsog_pkg::SAMPLE_W-1:0] ring_reg [wsog_pkg::WINDOW][wsog_pkg::AXES];
    logic signed [wsog_pkg::SUM_W-1:0]    sum_reg  [wsog_pkg::AXES];
    logic        [wsog_pkg::SQ_W-1:0]     sq_reg   [wsog_pkg::AXES];

    logic signed [wsog_pkg::DIFF_W-1:0] d_reg;
    logic        [wsog_pkg::NQ_W-1:0]   ss_reg;
    logic        [wsog_pkg::NQ_W-1:0]   nq_reg;
    logic        [wsog_pkg::SQR_W-1:0]  vv_reg;
    logic        [wsog_pkg::SQR_W-1:0]  oo_reg;
    logic        [wsog_pkg::NQ_W-1:0]   var_reg;
    logic        [wsog_pkg::DD_W-1:0]   dd_reg;
    logic        [wsog_pkg::MM_W-1:0]   mm_reg;
    logic        [wsog_pkg::MV_W-1:0]   mv_reg;

    logic                m_tvalid_reg;
    logic [47:0]         m_tdata_reg;
    logic                m_tuser_reg;

    // Selected axis operands
    logic signed [wsog_pkg::SAMPLE_W-1:0] v_sel, old_sel;
    logic signed [wsog_pkg::SUM_W-1:0]    sum_sel, v_ext, old_ext, nv15;
    logic        [wsog_pkg::SQ_W-1:0]     sq_sel;
    logic signed [2*wsog_pkg::SUM_W-1:0]  ss_full;
    logic signed [2*wsog_pkg::SAMPLE_W-1:0] vv_full, oo_full;
    logic signed [2*wsog_pkg::DIFF_W-1:0] dd_full;
    logic        [wsog_pkg::NQ_W-1:0]     q_ext;
    logic signed [wsog_pkg::NQ_W:0]       var_full;
    logic signed [wsog_pkg::SQ_W:0]       sq_upd;
    logic        [wsog_pkg::MV_W-1:0]     mv_full;

    // ---------------- sequencer ----------------
    always_comb
    begin
        ctl      = wsog_pkg::ucode(step_reg);
        hold_now = ((ctl.hold == wsog_pkg::HOLD_IN) && !s_tvalid) ||
                   ((ctl.hold == wsog_pkg::HOLD_OUT) && m_tvalid_reg && !m_tready);
        go       = !hold_now;
        if (hold_now)
            step_next = step_reg;
        else if (ctl.br_loop && (axis_reg != wsog_pkg::AXIS_LAST))
            step_next = ctl.target;
        else
            step_next = ctl.next;
    end

    assign s_tready = (ctl.hold == wsog_pkg::HOLD_IN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= wsog_pkg::STEP_IDLE;
        else
            step_reg <= step_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gate_mult_reg <= wsog_pkg::GATE_MULT_RESET;
        else if (cfg_we)
            gate_mult_reg <= cfg_wdata;
    end

    // ---------------- datapath ----------------
    always_comb
    begin
        v_sel    = samp_reg[axis_reg];
        old_sel  = ring_reg[slot_reg][axis_reg];
        sum_sel  = sum_reg[axis_reg];
        sq_sel   = sq_reg[axis_reg];
        v_ext    = wsog_pkg::SUM_W'(v_sel);
        old_ext  = wsog_pkg::SUM_W'(old_sel);
        nv15     = (v_ext <<< 4) - v_ext;
        ss_full  = sum_sel * sum_sel;
        vv_full  = v_sel * v_sel;
        oo_full  = old_sel * old_sel;
        q_ext    = wsog_pkg::NQ_W'(sq_sel);
        dd_full  = d_reg * d_reg;
        var_full = $signed({1'b0, nq_reg}) - $signed({1'b0, ss_reg});
        sq_upd   = $signed({1'b0, sq_sel}) + $signed({4'b0, vv_reg})
                   - $signed({4'b0, oo_reg});
        mv_full  = wsog_pkg::MV_W'(mm_reg) * wsog_pkg::MV_W'(var_reg);
    end

    // Operand and result registers of the shared datapath
    always_ff @(posedge clk)
    begin
        if (ctl.cap && go)
        begin
            samp_reg[0] <= s_tdata[15:0];
            samp_reg[1] <= s_tdata[31:16];
            samp_reg[2] <= s_tdata[47:32];
            mm_reg      <= wsog_pkg::MM_W'(gate_mult_reg) * wsog_pkg::MM_W'(gate_mult_reg);
        end
        if (ctl.calc_a)
        begin
            d_reg  <= nv15 - sum_sel;
            ss_reg <= ss_full[wsog_pkg::NQ_W-1:0];
            nq_reg <= (q_ext << 4) - q_ext;
            vv_reg <= vv_full[wsog_pkg::SQR_W-1:0];
            oo_reg <= oo_full[wsog_pkg::SQR_W-1:0];
        end
        if (ctl.calc_b)
        begin
            dd_reg  <= dd_full[wsog_pkg::DD_W-1:0];
            // clamp a negative variance term to zero
            var_reg <= var_full[wsog_pkg::NQ_W] ? '0 : var_full[wsog_pkg::NQ_W-1:0];
        end
        if (ctl.calc_c)
            mv_reg <= mv_full;
    end

    // Control state, ring and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg <= '0;
            slot_reg <= '0;
            ok_reg   <= 1'b0;
            for (int i = 0; i < wsog_pkg::WINDOW; i++)
                for (int a = 0; a < wsog_pkg::AXES; a++)
                    ring_reg[i][a] <= '0;
            for (int a = 0; a < wsog_pkg::AXES; a++)
            begin
                sum_reg[a] <= '0;
                sq_reg[a]  <= '0;
            end
        end
        else
        begin
            if (ctl.cap && go)
            begin
                axis_reg <= '0;
                ok_reg   <= 1'b1;
            end
            // the axis test already holds the old sums in d_reg, ss_reg, nq_reg
            if (ctl.calc_b)
            begin
                sum_reg[axis_reg] <= sum_sel + v_ext - old_ext;
                sq_reg[axis_reg]  <= sq_upd[wsog_pkg::SQ_W-1:0];
            end
            if (ctl.calc_d)
            begin
                ok_reg <= ok_reg & (wsog_pkg::MV_W'(dd_reg) <= mv_reg);
                if (axis_reg != wsog_pkg::AXIS_LAST)
                    axis_reg <= axis_reg + 1'b1;
            end
            if (ctl.commit && go)
            begin
                for (int a = 0; a < wsog_pkg::AXES; a++)
                    ring_reg[slot_reg][a] <= samp_reg[a];
                if (slot_reg == wsog_pkg::SLOT_W'(wsog_pkg::WINDOW - 1))
                    slot_reg <= '0;
                else
                    slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (ctl.commit && go)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit && go)
        begin
            m_tdata_reg <= {samp_reg[2], samp_reg[1], samp_reg[0]};
            m_tuser_reg <= ok_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- assertions ----------------
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("sample taken while a sample is in work");

    a_commit_last_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == wsog_pkg::STEP_COMMIT) |-> (axis_reg == wsog_pkg::AXIS_LAST))
        else $error("commit before all axes tested");

    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(step_reg) == wsog_pkg::STEP_COMMIT))
        else $error("result raised outside the commit step");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= wsog_pkg::SLOT_W'(wsog_pkg::WINDOW - 1))
        else $error("write slot out of ring");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 190;
    localparam int PHASES       = 7;

    typedef struct packed {
        logic        accepted;
        logic [47:0] echo;     // out_x [15:0], out_y [31:16], out_z [47:32]
    } verdict_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [3:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;   // pos_x [15:0], pos_y [31:16], pos_z [47:32]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;          // out_x [15:0], out_y [31:16], out_z [47:32]
    logic        m_tuser;          // accepted [0]

    window_sigma_outlier_gate DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Shadow of the block: sample ring, per-axis sums and the sigma multiplier
    shortint    ring_shadow [wsog_pkg::WINDOW][wsog_pkg::AXES];
    longint     axis_sum [wsog_pkg::AXES];
    longint     axis_sq_sum [wsog_pkg::AXES];
    int         next_slot;
    logic [3:0] sigma_mult;

    logic [47:0] pending_samples [$];
    verdict_t    expected_verdicts [$];

    bit    steady_flow = 1'b0;
    int    hold_asks = 0;
    int    hold_served = 0;
    int    mismatches = 0;
    int    samples_sent = 0;
    int    results_seen = 0;
    int    accepted_seen = 0;
    int    idle_cycles = 0;

    // Trajectory used to shape the random samples
    int    track_center [wsog_pkg::AXES];
    int    track_spread = 40;

    const string echo_names [wsog_pkg::AXES] = '{"out_x", "out_y", "out_z"};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(12, 60);
    endfunction

    function automatic logic [47:0] pack3(input int x, input int y, input int z);
        return {z[15:0], y[15:0], x[15:0]};
    endfunction

    // Judge one sample against the window, then roll it into the ring
    function automatic verdict_t judge_sample(input logic [47:0] word);
        verdict_t r;
        longint   v;
        longint   dev;
        longint   spread;
        longint   mm;
        longint   old;
        r.accepted = 1'b1;
        r.echo = word;
        mm = longint'(sigma_mult) * longint'(sigma_mult);
        for (int a = 0; a < wsog_pkg::AXES; a++)
        begin
            v = longint'($signed(word[a*16 +: 16]));
            dev = wsog_pkg::WINDOW * v - axis_sum[a];
            spread = wsog_pkg::WINDOW * axis_sq_sum[a] - axis_sum[a] * axis_sum[a];
            if (spread < 0)
                spread = 0;
            if (dev * dev > mm * spread)
                r.accepted = 1'b0;
            old = longint'(ring_shadow[next_slot][a]);
            axis_sum[a] += v - old;
            axis_sq_sum[a] += v * v - old * old;
            ring_shadow[next_slot][a] = shortint'(v);
        end
        next_slot = (next_slot + 1) % wsog_pkg::WINDOW;
        return r;
    endfunction

    // Mostly samples around a point that jumps at random, with outliers and raw noise mixed in
    function automatic logic [47:0] next_sample();
        logic [47:0] w;
        int pick;
        int offs;
        int p;
        int hit_axis;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            w[31:0]  = $urandom;
            w[47:32] = 16'($urandom_range(0, 65535));
            return w;
        end
        if (pick < 12)
        begin
            for (int a = 0; a < wsog_pkg::AXES; a++)
                track_center[a] = int'($urandom_range(0, 65535)) - 32768;
            case ($urandom_range(0, 5))
                0: track_spread = 0;
                1: track_spread = 2;
                2: track_spread = 30;
                3: track_spread = 500;
                4: track_spread = 6000;
                default: track_spread = 40000;
            endcase
        end
        hit_axis = (pick < 27) ? int'($urandom_range(0, wsog_pkg::AXES - 1)) : -1;
        for (int a = 0; a < wsog_pkg::AXES; a++)
        begin
            if (a == hit_axis)
                offs = (int'($urandom_range(0, 1)) * 2 - 1)
                       * (track_spread * int'($urandom_range(1, 6)) + int'($urandom_range(1, 50)));
            else
                offs = int'($urandom_range(0, 2 * track_spread)) - track_spread;
            p = track_center[a] + offs;
            if (p > 32767)
                p = 32767;
            if (p < -32768)
                p = -32768;
            w[a*16 +: 16] = p[15:0];
        end
        return w;
    endfunction

    // Sender: offer pending samples, with random gaps after each transfer unless the flow is steady
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_verdicts.push_back(judge_sample(s_tdata));
                samples_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    s_tvalid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_samples.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_samples.pop_front();
                    gap_left <= steady_flow ? 0 : pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: check each result transfer, stall at random or hold off on request
    int stall_left = 0;
    int hold_left = 0;
    always @(posedge clk)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("result with no sample waiting: tdata=%h tuser=%b", m_tdata, m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    results_seen++;
                    if (want.accepted)
                        accepted_seen++;
                    if (m_tuser !== want.accepted)
                    begin
                        $error("accepted: expected %0b, got %0b", want.accepted, m_tuser);
                        mismatches++;
                    end
                    for (int a = 0; a < wsog_pkg::AXES; a++)
                        if (m_tdata[a*16 +: 16] !== want.echo[a*16 +: 16])
                        begin
                            $error("%s: expected %0d, got %0d", echo_names[a],
                                   $signed(want.echo[a*16 +: 16]),
                                   $signed(m_tdata[a*16 +: 16]));
                            mismatches++;
                        end
                end
            end
            if (hold_asks != hold_served)
            begin
                hold_served <= hold_served + 1;
                hold_left   <= HOLD_CYCLES;
                m_tready    <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (steady_flow)
                m_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end
            else
            begin
                m_tready   <= 1'b1;
                stall_left <= pick_gap();
            end
        end
    end

    // Watchdog: end the run if no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_verdicts.size());
            $display("window_sigma_outlier_gate verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Hold until every sample is out and every result is back, then let the block settle
    task automatic wait_quiet();
        while (pending_samples.size() > 0 || s_tvalid || expected_verdicts.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_sigma_mult(input logic [3:0] m);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sigma_mult = m;
        @(negedge clk);
    endtask

    initial
    begin
        logic [3:0] mult_plan [PHASES];
        mult_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd4};
        for (int i = 0; i < wsog_pkg::WINDOW; i++)
            for (int a = 0; a < wsog_pkg::AXES; a++)
                ring_shadow[i][a] = 0;
        for (int a = 0; a < wsog_pkg::AXES; a++)
        begin
            axis_sum[a]     = 0;
            axis_sq_sum[a]  = 0;
            track_center[a] = 0;
        end
        next_slot  = 0;
        sigma_mult = wsog_pkg::GATE_MULT_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: zero window from reset, field extremes, then a constant window
        pending_samples.push_back(pack3(0, 0, 0));
        pending_samples.push_back(pack3(1, 0, 0));
        pending_samples.push_back(pack3(32767, -32768, 0));
        pending_samples.push_back(pack3(-32768, 32767, -1));
        pending_samples.push_back(pack3(-1, -1, -1));
        pending_samples.push_back(pack3(32767, 32767, 32767));
        pending_samples.push_back(pack3(-32768, -32768, -32768));
        pending_samples.push_back(pack3(16'h5555, 16'hAAAA, 16'h5555));
        repeat (wsog_pkg::WINDOW + 1)
            pending_samples.push_back(pack3(100, -200, 300));
        pending_samples.push_back(pack3(101, -200, 300));
        wait_quiet();

        for (int p = 0; p < PHASES; p++)
        begin
            write_sigma_mult(mult_plan[p]);
            steady_flow = (p == 3);
            // At zero gate, a constant window lets through only an equal sample
            if (mult_plan[p] == 4'd0)
            begin
                repeat (wsog_pkg::WINDOW)
                    pending_samples.push_back(pack3(-7, 7, 12345));
                pending_samples.push_back(pack3(-7, 7, 12345));
                pending_samples.push_back(pack3(-7, 8, 12345));
            end
            repeat (PHASE_ITEMS)
                pending_samples.push_back(next_sample());
            if (p == 1)
            begin
                // Keep offering while the receiver holds off, so the block backs up
                repeat (40) @(negedge clk);
                hold_asks = hold_asks + 1;
            end
            wait_quiet();
        end

        $display("%0d samples judged over %0d gate settings, %0d results checked",
                 samples_sent, PHASES + 1, results_seen);
        $display("%0d accepted, %0d rejected, %0d mismatches",
                 accepted_seen, results_seen - accepted_seen, mismatches);
        if (mismatches == 0 && expected_verdicts.size() == 0)
            $display("window_sigma_outlier_gate verification clean");
        else
            $display("window_sigma_outlier_gate verification failed");
        $finish;
    end

endmodule

// ===== window_sigma_outlier_gate.f =====
rtl/wsog_pkg.sv
rtl/window_sigma_outlier_gate.sv
verif/tb_top.sv
